// ===== hdl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared codes for the box overlap and push vector block.
// ----------------------------------------------------------------------------
package aabb_pkg;

   typedef enum logic [1:0] {
      ST_INVALID     = 2'd0,
      ST_SEPARATED   = 2'd1,
      ST_PENETRATING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

endpackage

// ===== hdl/aabb_overlap_and_push_vector.sv =====
// ----------------------------------------------------------------------------
// aabb_overlap_and_push_vector
// Overlap test of two 3D boxes with gap length or minimum push vector.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the twelve box coordinates on req_* and raise start. An item is
//   taken at every rising edge with start high and busy low. busy is always
//   low: the block is a fully pipelined datapath and takes one item per cycle.
//   Each result appears on rsp_* for exactly one cycle with rsp_valid high.
//   Results leave in the order the items came in.
// Pipeline:
//   Four front stages (input register, per-axis overlap and candidates,
//   squares and push select, sum of squares) feed an integer square root
//   that resolves one root bit per stage over COORD_BITS + 2 stages, then
//   the output register. The root chain sets the latency; the rate is one
//   item per cycle throughout.
// Reset:
//   Synchronous, active high; clears all valid bits. Payload is not reset.
// Stall:
//   The receiver cannot hold results off, so nothing ever stalls.
// ----------------------------------------------------------------------------
module aabb_overlap_and_push_vector
   import aabb_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_min_x,
   input  logic signed [COORD_BITS-1:0] req_a_min_y,
   input  logic signed [COORD_BITS-1:0] req_a_min_z,
   input  logic signed [COORD_BITS-1:0] req_a_max_x,
   input  logic signed [COORD_BITS-1:0] req_a_max_y,
   input  logic signed [COORD_BITS-1:0] req_a_max_z,
   input  logic signed [COORD_BITS-1:0] req_b_min_x,
   input  logic signed [COORD_BITS-1:0] req_b_min_y,
   input  logic signed [COORD_BITS-1:0] req_b_min_z,
   input  logic signed [COORD_BITS-1:0] req_b_max_x,
   input  logic signed [COORD_BITS-1:0] req_b_max_y,
   input  logic signed [COORD_BITS-1:0] req_b_max_z,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [COORD_BITS:0]          rsp_gap_distance,
   output logic [COORD_BITS-1:0]        rsp_push_depth,
   output logic [1:0]                   rsp_push_axis,
   output logic signed [COORD_BITS:0]   rsp_push_amount
);

   localparam int C  = COORD_BITS;
   localparam int N  = C + 2;      // root bits resolved, one per stage
   localparam int W  = 2 * N;      // radicand width
   localparam int RW = N + 2;      // partial remainder width
   localparam int SW = 2 * C;      // one square

   // fields that ride along the root chain
   typedef struct packed {
      status_type         status;
      logic [C-1:0]       depth;
      axis_type           axis;
      logic signed [C:0]  amount;
   } meta_type;

   assign busy = 1'b0;

   // ---------------- stage A: input register ----------------
   logic                 a_v_ff;
   logic signed [C-1:0]  amin_ff [3];
   logic signed [C-1:0]  amax_ff [3];
   logic signed [C-1:0]  bmin_ff [3];
   logic signed [C-1:0]  bmax_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      amin_ff[0] <= req_a_min_x; amin_ff[1] <= req_a_min_y; amin_ff[2] <= req_a_min_z;
      amax_ff[0] <= req_a_max_x; amax_ff[1] <= req_a_max_y; amax_ff[2] <= req_a_max_z;
      bmin_ff[0] <= req_b_min_x; bmin_ff[1] <= req_b_min_y; bmin_ff[2] <= req_b_min_z;
      bmax_ff[0] <= req_b_max_x; bmax_ff[1] <= req_b_max_y; bmax_ff[2] <= req_b_max_z;
   end

   // ---------------- stage B: per-axis overlap and push candidates ----------
   logic                 b_v_ff;
   status_type           b_st_ff, b_st_in;
   logic [C-1:0]         b_gap_ff [3];
   logic [C-1:0]         b_gap_in [3];
   logic signed [C:0]    b_d_ff [3];
   logic signed [C:0]    b_d_in [3];
   logic [C:0]           b_mag_ff [3];
   logic [C:0]           b_mag_in [3];

   always_comb begin
      logic                ok, pen;
      logic signed [C-1:0] hi, lo;
      logic signed [C:0]   ov, pos, neg, ng;
      logic                in_a, in_b;
      ok  = 1'b1;
      pen = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (amin_ff[i] > amax_ff[i] || bmin_ff[i] > bmax_ff[i]) ok = 1'b0;
         hi   = (amax_ff[i] < bmax_ff[i]) ? amax_ff[i] : bmax_ff[i];
         lo   = (amin_ff[i] > bmin_ff[i]) ? amin_ff[i] : bmin_ff[i];
         ov   = {hi[C-1], hi} - {lo[C-1], lo};
         in_a = (amin_ff[i] < lo) && (lo < amax_ff[i]);
         in_b = (bmin_ff[i] < lo) && (lo < bmax_ff[i]);
         if (ov[C]) pen = 1'b0;
         else if (ov == '0 && !in_a && !in_b) pen = 1'b0;
         ng   = -ov;
         b_gap_in[i] = ov[C] ? ng[C-1:0] : '0;
         pos  = {bmax_ff[i][C-1], bmax_ff[i]} - {amin_ff[i][C-1], amin_ff[i]};
         neg  = {amax_ff[i][C-1], amax_ff[i]} - {bmin_ff[i][C-1], bmin_ff[i]};
         b_d_in[i]   = (pos < neg) ? pos : -neg;
         b_mag_in[i] = b_d_in[i][C] ? C'(0) - C'(0) + (-b_d_in[i]) : b_d_in[i];
      end
      if (!ok)       b_st_in = ST_INVALID;
      else if (!pen) b_st_in = ST_SEPARATED;
      else           b_st_in = ST_PENETRATING;
   end

   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else       b_v_ff <= a_v_ff;
   end

   always_ff @(posedge clock) begin
      b_st_ff <= b_st_in;
      for (int i = 0; i < 3; i++) begin
         b_gap_ff[i] <= b_gap_in[i];
         b_d_ff[i]   <= b_d_in[i];
         b_mag_ff[i] <= b_mag_in[i];
      end
   end

   // ---------------- stage C: squares and push select ----------------
   logic           c_v_ff;
   logic [SW-1:0]  c_sq_ff [3];
   meta_type       c_meta_ff, c_meta_in;

   always_comb begin
      logic [C:0]        best;
      logic signed [C:0] bd;
      axis_type          ax;
      best = b_mag_ff[0];
      bd   = b_d_ff[0];
      ax   = AXIS_X;
      if (b_mag_ff[1] < best) begin
         best = b_mag_ff[1]; bd = b_d_ff[1]; ax = AXIS_Y;
      end
      if (b_mag_ff[2] < best) begin
         best = b_mag_ff[2]; bd = b_d_ff[2]; ax = AXIS_Z;
      end
      c_meta_in.status = b_st_ff;
      if (b_st_ff == ST_PENETRATING) begin
         c_meta_in.depth  = best[C-1:0];
         c_meta_in.axis   = ax;
         c_meta_in.amount = bd;
      end else begin
         c_meta_in.depth  = '0;
         c_meta_in.axis   = AXIS_X;
         c_meta_in.amount = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else       c_v_ff <= b_v_ff;
   end

   always_ff @(posedge clock) begin
      c_meta_ff <= c_meta_in;
      for (int i = 0; i < 3; i++) begin
         // gaps only count for a separated result
         c_sq_ff[i] <= (b_st_ff == ST_SEPARATED) ? b_gap_ff[i] * b_gap_ff[i] : '0;
      end
   end

   // ---------------- stage D: sum of squares ----------------
   logic           d_v_ff;
   logic [W-1:0]   d_rad_ff;
   meta_type       d_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else       d_v_ff <= c_v_ff;
   end

   always_ff @(posedge clock) begin
      d_rad_ff  <= W'(c_sq_ff[0]) + W'(c_sq_ff[1]) + W'(c_sq_ff[2]);
      d_meta_ff <= c_meta_ff;
   end

   // ---------------- root chain: one bit per stage ----------------
   logic            r_v_ff    [N];
   logic [W-1:0]    r_rad_ff  [N];
   logic [RW-1:0]   r_rem_ff  [N];
   logic [N-1:0]    r_root_ff [N];
   meta_type        r_meta_ff [N];

   for (genvar s = 0; s < N; s++) begin : g_root
      logic            v_prev;
      logic [W-1:0]    rad_prev;
      logic [RW-1:0]   rem_prev, cur, trial;
      logic [N-1:0]    root_prev;
      meta_type        meta_prev;

      if (s == 0) begin : g_first
         assign v_prev    = d_v_ff;
         assign rad_prev  = d_rad_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign meta_prev = d_meta_ff;
      end else begin : g_next
         assign v_prev    = r_v_ff[s-1];
         assign rad_prev  = r_rad_ff[s-1];
         assign rem_prev  = r_rem_ff[s-1];
         assign root_prev = r_root_ff[s-1];
         assign meta_prev = r_meta_ff[s-1];
      end

      assign cur   = {rem_prev[RW-3:0], rad_prev[W-1:W-2]};
      assign trial = {root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) r_v_ff[s] <= 1'b0;
         else       r_v_ff[s] <= v_prev;
      end

      always_ff @(posedge clock) begin
         r_rad_ff[s]  <= {rad_prev[W-3:0], 2'b00};
         r_meta_ff[s] <= meta_prev;
         if (cur >= trial) begin
            r_rem_ff[s]  <= cur - trial;
            r_root_ff[s] <= {root_prev[N-2:0], 1'b1};
         end else begin
            r_rem_ff[s]  <= cur;
            r_root_ff[s] <= {root_prev[N-2:0], 1'b0};
         end
      end
   end

   // ---------------- output register ----------------
   logic               o_v_ff;
   logic [1:0]         o_st_ff;
   logic [C:0]         o_gap_ff;
   logic [C-1:0]       o_depth_ff;
   logic [1:0]         o_axis_ff;
   logic signed [C:0]  o_amount_ff;

   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else       o_v_ff <= r_v_ff[N-1];
   end

   always_ff @(posedge clock) begin
      o_st_ff     <= r_meta_ff[N-1].status;
      o_gap_ff    <= r_root_ff[N-1][C:0];
      o_depth_ff  <= r_meta_ff[N-1].depth;
      o_axis_ff   <= r_meta_ff[N-1].axis;
      o_amount_ff <= r_meta_ff[N-1].amount;
   end

   assign rsp_valid        = o_v_ff;
   assign rsp_status       = o_st_ff;
   assign rsp_gap_distance = o_gap_ff;
   assign rsp_push_depth   = o_depth_ff;
   assign rsp_push_axis    = o_axis_ff;
   assign rsp_push_amount  = o_amount_ff;

   // ---------------- checks ----------------
   a_sep_no_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SEPARATED |->
         rsp_push_depth == '0 && rsp_push_amount == '0 && rsp_push_axis == AXIS_X)
      else $error("separated result carries a push");

   a_pen_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_SEPARATED |-> rsp_gap_distance == '0)
      else $error("gap reported on a non-separated result");

   a_depth_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_PENETRATING |->
         rsp_push_depth == (rsp_push_amount[C] ? C'(-rsp_push_amount) : rsp_push_amount[C-1:0]))
      else $error("push depth does not match push amount");

endmodule

// ===== test/aabb_overlap_and_push_vector_tb.sv =====
// ----------------------------------------------------------------------------
// aabb_overlap_and_push_vector_tb
// Box overlap testbench: directed table of box pairs, then random pairs with
// idle bursts, every result checked against an in-bench push/gap predictor or a typed-in expectation.
// ----------------------------------------------------------------------------
module aabb_overlap_and_push_vector_tb
   import aabb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 32;
   localparam int LATENCY = CB + 7;
   localparam int N_RANDOM = 430;
   localparam longint CYCLE_LIMIT = 200000;

   typedef logic signed [CB-1:0] coord_type;

   // one box pair: index 0..2 = x,y,z
   typedef struct {
      coord_type amin[3];
      coord_type amax[3];
      coord_type bmin[3];
      coord_type bmax[3];
   } box_pair_type;

   typedef struct {
      status_type           status;
      logic [CB:0]          gap;
      logic [CB-1:0]        depth;
      axis_type             axis;
      logic signed [CB:0]   amount;
   } contact_type;

   // directed row: pair, plus optional typed-in expectation
   typedef struct {
      box_pair_type pair;
      bit           has_fixed;
      contact_type  fixed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_a_min_x = '0, req_a_min_y = '0, req_a_min_z = '0;
   coord_type req_a_max_x = '0, req_a_max_y = '0, req_a_max_z = '0;
   coord_type req_b_min_x = '0, req_b_min_y = '0, req_b_min_z = '0;
   coord_type req_b_max_x = '0, req_b_max_y = '0, req_b_max_z = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [CB:0]         rsp_gap_distance;
   logic [CB-1:0]       rsp_push_depth;
   logic [1:0]          rsp_push_axis;
   logic signed [CB:0]  rsp_push_amount;

   contact_type pending_contacts[$];
   int          error_count = 0;
   longint      cycle_count = 0;

   always #4 clock = ~clock;

   aabb_overlap_and_push_vector #(.COORD_BITS(CB)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_min_x(req_a_min_x), .req_a_min_y(req_a_min_y), .req_a_min_z(req_a_min_z),
      .req_a_max_x(req_a_max_x), .req_a_max_y(req_a_max_y), .req_a_max_z(req_a_max_z),
      .req_b_min_x(req_b_min_x), .req_b_min_y(req_b_min_y), .req_b_min_z(req_b_min_z),
      .req_b_max_x(req_b_max_x), .req_b_max_y(req_b_max_y), .req_b_max_z(req_b_max_z),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_gap_distance(rsp_gap_distance), .rsp_push_depth(rsp_push_depth),
      .rsp_push_axis(rsp_push_axis), .rsp_push_amount(rsp_push_amount)
   );

   // floor square root of a sum of up to three 66-bit squares
   function automatic logic [CB:0] floor_root(logic [2*CB+3:0] s);
      logic [CB:0]       r;
      logic [CB:0]       t;
      logic [2*CB+3:0]   tsq;
      r = '0;
      for (int b = CB; b >= 0; b--) begin
         t = r | ((CB+1)'(1) << b);
         tsq = (2*CB+4)'(t) * (2*CB+4)'(t);
         if (tsq <= s) r = t;
      end
      return r;
   endfunction

   function automatic contact_type predict_contact(box_pair_type p);
      contact_type      c;
      longint           hi, lo, ov[3], pos, neg, d, mag, best;
      bit               valid, all_pen, in_a, in_b;
      logic [2*CB+3:0]  sum;
      logic [CB:0]      g;
      c = '{ST_INVALID, '0, '0, AXIS_X, '0};
      valid = 1;
      all_pen = 1;
      for (int i = 0; i < 3; i++)
         if (p.amin[i] > p.amax[i] || p.bmin[i] > p.bmax[i]) valid = 0;
      if (!valid) return c;
      for (int i = 0; i < 3; i++) begin
         hi = (p.amax[i] < p.bmax[i]) ? p.amax[i] : p.bmax[i];
         lo = (p.amin[i] > p.bmin[i]) ? p.amin[i] : p.bmin[i];
         ov[i] = hi - lo;
         if (ov[i] < 0) all_pen = 0;
         else if (ov[i] == 0) begin
            // zero-width overlap penetrates only strictly inside a box
            in_a = (p.amin[i] < lo) && (lo < p.amax[i]);
            in_b = (p.bmin[i] < lo) && (lo < p.bmax[i]);
            if (!in_a && !in_b) all_pen = 0;
         end
      end
      if (!all_pen) begin
         sum = '0;
         for (int i = 0; i < 3; i++) begin
            g = (ov[i] < 0) ? (CB+1)'(-ov[i]) : '0;
            sum += (2*CB+4)'(g) * (2*CB+4)'(g);
         end
         c.status = ST_SEPARATED;
         c.gap = floor_root(sum);
         return c;
      end
      best = 0;
      for (int i = 0; i < 3; i++) begin
         pos = longint'(p.bmax[i]) - longint'(p.amin[i]);
         neg = longint'(p.amax[i]) - longint'(p.bmin[i]);
         d = (pos < neg) ? pos : -neg;   // tie -> negative push
         mag = (d < 0) ? -d : d;
         if (i == 0 || mag < best) begin  // tie -> lower axis
            best = mag;
            c.amount = d[CB:0];
            c.axis = axis_type'(i);
         end
      end
      c.status = ST_PENETRATING;
      c.depth = best[CB-1:0];
      return c;
   endfunction

   function automatic box_pair_type make_pair(coord_type a0, coord_type a1,
                                              coord_type b0, coord_type b1);
      box_pair_type p;
      for (int i = 0; i < 3; i++) begin
         p.amin[i] = a0; p.amax[i] = a1; p.bmin[i] = b0; p.bmax[i] = b1;
      end
      return p;
   endfunction

   // random coordinate: mostly small, sometimes full range
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 3))
         0:       return coord_type'($urandom);
         1:       return coord_type'($urandom_range(0, 8)) - 4 <<< 16;
         default: return coord_type'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic box_pair_type rand_pair();
      box_pair_type p;
      coord_type    t;
      for (int i = 0; i < 3; i++) begin
         p.amin[i] = rand_coord(); p.amax[i] = rand_coord();
         p.bmin[i] = rand_coord(); p.bmax[i] = rand_coord();
         // mostly well-formed boxes; swap reversed min/max pairs
         if ($urandom_range(0, 15) != 0) begin
            if (p.amin[i] > p.amax[i]) begin t = p.amin[i]; p.amin[i] = p.amax[i]; p.amax[i] = t; end
            if (p.bmin[i] > p.bmax[i]) begin t = p.bmin[i]; p.bmin[i] = p.bmax[i]; p.bmax[i] = t; end
            // sometimes share an edge to hit zero-width overlap
            if ($urandom_range(0, 7) == 0) p.bmin[i] = p.amax[i];
            if (p.bmin[i] > p.bmax[i]) p.bmax[i] = p.bmin[i];
         end
      end
      return p;
   endfunction

   // drive one item and hold until accepted (busy low at the edge)
   task automatic send_item(box_pair_type p, bit has_fixed, contact_type fixed);
      contact_type c;
      start <= 1'b1;
      req_a_min_x <= p.amin[0]; req_a_min_y <= p.amin[1]; req_a_min_z <= p.amin[2];
      req_a_max_x <= p.amax[0]; req_a_max_y <= p.amax[1]; req_a_max_z <= p.amax[2];
      req_b_min_x <= p.bmin[0]; req_b_min_y <= p.bmin[1]; req_b_min_z <= p.bmin[2];
      req_b_max_x <= p.bmax[0]; req_b_max_y <= p.bmax[1]; req_b_max_z <= p.bmax[2];
      c = predict_contact(p);
      if (has_fixed) c = fixed;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_contacts.push_back(c);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clock);
   endtask

   // result checker: sampled at the edge that ends the strobe cycle
   always @(posedge clock) begin
      contact_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_contacts.size() == 0) begin
            $display("%0t: result with none expected, status %0d", $time, rsp_status);
            error_count++;
         end else begin
            e = pending_contacts.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               error_count++;
            end
            if (rsp_gap_distance !== e.gap) begin
               $display("%0t: gap exp %0h got %0h", $time, e.gap, rsp_gap_distance);
               error_count++;
            end
            if (rsp_push_depth !== e.depth) begin
               $display("%0t: depth exp %0h got %0h", $time, e.depth, rsp_push_depth);
               error_count++;
            end
            if (rsp_push_axis !== e.axis) begin
               $display("%0t: axis exp %0d got %0d", $time, e.axis, rsp_push_axis);
               error_count++;
            end
            if (rsp_push_amount !== e.amount) begin
               $display("%0t: amount exp %0h got %0h", $time, e.amount, rsp_push_amount);
               error_count++;
            end
         end
      end
   end

   // hard stop on hang
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("aabb_overlap_and_push_vector_tb: done, errors");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      box_pair_type p;
      contact_type  none;
      coord_type    big, neg_big;
      int           drain;
      none = '{ST_INVALID, '0, '0, AXIS_X, '0};
      big = {1'b0, {(CB-1){1'b1}}};
      neg_big = {1'b1, {(CB-1){1'b0}}};

      // invalid boxes: A reversed, B reversed (all fields zero)
      r.pair = make_pair(10, 5, 0, 20); r.has_fixed = 1; r.fixed = none; rows.push_back(r);
      r.pair = make_pair(0, 20, big, neg_big); rows.push_back(r);
      // identical unit boxes: push tie resolves negative on x
      r.pair = make_pair(0, 32'h10000, 0, 32'h10000); r.has_fixed = 1;
      r.fixed = '{ST_PENETRATING, '0, 32'h10000, AXIS_X, -33'sh10000}; rows.push_back(r);
      // touching faces: zero gap, separated
      r.pair = make_pair(0, 32'h10000, 32'h10000, 32'h20000);
      r.fixed = '{ST_SEPARATED, '0, '0, AXIS_X, '0}; rows.push_back(r);
      // extremes of the coordinate range, far apart and fully nested
      r.has_fixed = 0;
      r.pair = make_pair(neg_big, neg_big, big, big); rows.push_back(r);
      r.pair = make_pair(neg_big, big, neg_big, big); rows.push_back(r);
      r.pair = make_pair(neg_big, big, 0, 0); rows.push_back(r);
      r.pair = make_pair(neg_big, neg_big + 1, big - 1, big); rows.push_back(r);
      // degenerate B strictly inside A: zero width still penetrates
      r.pair = make_pair(0, 100, 50, 50); rows.push_back(r);
      // degenerate point on the face: resting contact
      r.pair = make_pair(0, 100, 100, 100); rows.push_back(r);
      // different depths per axis: y and z win
      p = make_pair(0, 1000, 100, 2000); p.bmin[1] = 900; rows.push_back('{p, 0, none});
      p.bmin[2] = 950; rows.push_back('{p, 0, none});
      // positive push
      p = make_pair(100, 2000, 0, 300); rows.push_back('{p, 0, none});
      // separated on several axes, gap length
      p = make_pair(0, 32'h30000, 32'h70000, 32'h80000); p.bmin[2] = 0; rows.push_back('{p, 0, none});
      p = make_pair(0, 10, 20, 30); rows.push_back('{p, 0, none});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[k]) send_item(rows[k].pair, rows[k].has_fixed, rows[k].fixed);

      for (int n = 0; n < N_RANDOM; n++) begin
         // idle bursts except in the last stretch
         if (n < N_RANDOM - 60 && $urandom_range(0, 5) == 0) idle_burst();
         send_item(rand_pair(), 0, none);
      end
      start <= 1'b0;

      drain = 0;
      while (pending_contacts.size() != 0 && drain < 10 * LATENCY) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 5) @(posedge clock);

      if (error_count == 0 && pending_contacts.size() == 0)
         $display("aabb_overlap_and_push_vector_tb: done, clean");
      else
         $display("aabb_overlap_and_push_vector_tb: done, errors");
      $finish;
   end

endmodule
